// ----- hw/rtl/lif_pkg.sv -----
package lif_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_DECAY_GAIN       = 3'd0;
   localparam logic [2:0] CSR_CURRENT_GAIN     = 3'd1;
   localparam logic [2:0] CSR_DRIVE_OFFSET     = 3'd2;
   localparam logic [2:0] CSR_FIRE_THRESHOLD   = 3'd3;
   localparam logic [2:0] CSR_REFRACTORY_TICKS = 3'd4;
   localparam logic [2:0] CSR_ID_OFFSET        = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Decoupling queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Q16.16 rounding: half an LSB of the result, in the Q32.32 product
   localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

   typedef struct packed {
      logic        [11:0] neuron_index;
      logic signed [31:0] syn_current;
   } req_type;

   typedef struct packed {
      logic               spiked;
      logic        [23:0] spike_id;
      logic signed [31:0] membrane_out;
      logic        [6:0]  refractory_left;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] decay_gain;
      logic signed [31:0] current_gain;
      logic signed [31:0] drive_offset;
      logic signed [31:0] fire_threshold;
      logic        [6:0]  refractory_ticks;
      logic        [23:0] id_offset;
   } cfg_type;

   // One queued beat, already classified
   typedef struct packed {
      logic        [11:0] idx;
      logic signed [31:0] cur;
      logic               oob;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type ent;
   } qhead_type;

   // Back-to-front control
   typedef struct packed {
      logic pop;
      logic clearing;
   } bctl_type;

   // Per-neuron state word
   typedef struct packed {
      logic signed [31:0] membrane;
      logic        [6:0]  refr;
   } mem_word_type;

endpackage

// ----- hw/rtl/lif_front.sv -----
module lif_front #(
   parameter int NEURONS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  lif_pkg::req_type   req_data,
   input  lif_pkg::bctl_type  bctl,
   output lif_pkg::qhead_type qhead
);

   lif_pkg::qent_type               entries_ff [lif_pkg::QDEPTH];
   logic [lif_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [lif_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [lif_pkg::QCNT_W-1:0]      count_ff;
   logic [lif_pkg::QCNT_W-1:0]      count_in;
   logic                            push;
   logic                            pop;
   lif_pkg::qent_type               ent_in;

   // Busy while the state memory is cleared or the queue is full
   assign busy = bctl.clearing || (count_ff == lif_pkg::QCNT_W'(lif_pkg::QDEPTH));
   assign push = start && !busy;
   assign pop  = bctl.pop;

   // Classify: flag indexes past the neuron array
   always_comb begin
      ent_in.idx = req_data.neuron_index;
      ent_in.cur = req_data.syn_current;
      ent_in.oob = (32'(req_data.neuron_index) >= 32'(NEURONS));
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= ent_in;
      end
   end

   assign qhead.valid = (count_ff != '0);
   assign qhead.ent   = entries_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/lif_back.sv -----
module lif_back #(
   parameter int NEURONS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  lif_pkg::cfg_type   cfg,
   input  lif_pkg::qhead_type qhead,
   output lif_pkg::bctl_type  bctl,
   output logic               rsp_valid,
   output lif_pkg::rsp_type   rsp_data
);

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam logic signed [49:0] SUM_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SUM_MIN = -50'sd2147483648;

   // State memory
   lif_pkg::mem_word_type mem_ff [NEURONS];
   lif_pkg::mem_word_type rd_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   lif_pkg::mem_word_type mem_wdata;
   logic [AW-1:0]         raddr;

   // Clearing pass
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;

   // Stage A: read data back, multiply
   logic                a_valid_ff;
   logic [11:0]         a_idx_ff;
   logic signed [31:0]  a_cur_ff;
   logic                a_oob_ff;

   // Stage B: round products
   logic                b_valid_ff;
   logic [11:0]         b_idx_ff;
   logic                b_oob_ff;
   lif_pkg::mem_word_type b_word_ff;
   logic signed [63:0]  b_p1_ff;
   logic signed [63:0]  b_p2_ff;
   logic signed [63:0]  b_p1_in;
   logic signed [63:0]  b_p2_in;

   // Stage C: sum, saturate, compare, write back
   logic                c_valid_ff;
   logic [11:0]         c_idx_ff;
   logic                c_oob_ff;
   lif_pkg::mem_word_type c_word_ff;
   logic signed [47:0]  c_q1_ff;
   logic signed [47:0]  c_q2_ff;
   logic signed [63:0]  c_t1;
   logic signed [63:0]  c_t2;
   logic signed [47:0]  c_q1_in;
   logic signed [47:0]  c_q2_in;

   logic signed [49:0]  sum;
   logic signed [31:0]  sat;
   lif_pkg::mem_word_type new_word;
   lif_pkg::rsp_type    rsp_data_in;
   logic                rsp_valid_ff;
   lif_pkg::rsp_type    rsp_data_ff;

   logic hazard;
   logic issue;

   // Hold the head while an older beat for the same neuron is still in flight
   always_comb begin
      hazard = !qhead.ent.oob && (
               (a_valid_ff && !a_oob_ff && (a_idx_ff == qhead.ent.idx)) ||
               (b_valid_ff && !b_oob_ff && (b_idx_ff == qhead.ent.idx)) ||
               (c_valid_ff && !c_oob_ff && (c_idx_ff == qhead.ent.idx)));
   end

   assign issue         = qhead.valid && !hazard && !clr_active_ff;
   assign bctl.pop      = issue;
   assign bctl.clearing = clr_active_ff;
   assign raddr         = AW'(qhead.ent.idx);

   // Clearing pass after reset, one neuron per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(NEURONS - 1)) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // Memory port: clear writes zeros, otherwise stage C writes back
   always_comb begin
      if (clr_active_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = c_valid_ff && !c_oob_ff;
         mem_waddr = AW'(c_idx_ff);
         mem_wdata = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (issue && !qhead.ent.oob) begin
         rd_ff <= mem_ff[raddr];
      end
   end

   // Valid bits of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= issue;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   // Stage A: two products in parallel
   assign b_p1_in = $signed(rd_ff.membrane) * $signed(cfg.decay_gain);
   assign b_p2_in = $signed(a_cur_ff) * $signed(cfg.current_gain);

   // Stage B: round half up to Q16.16
   assign c_t1    = b_p1_ff + lif_pkg::ROUND_HALF;
   assign c_t2    = b_p2_ff + lif_pkg::ROUND_HALF;
   assign c_q1_in = c_t1[63:16];
   assign c_q2_in = c_t2[63:16];

   // Pipeline payload
   always_ff @(posedge clock) begin
      a_idx_ff  <= qhead.ent.idx;
      a_cur_ff  <= qhead.ent.cur;
      a_oob_ff  <= qhead.ent.oob;

      b_idx_ff  <= a_idx_ff;
      b_oob_ff  <= a_oob_ff;
      b_word_ff <= rd_ff;
      b_p1_ff   <= b_p1_in;
      b_p2_ff   <= b_p2_in;

      c_idx_ff  <= b_idx_ff;
      c_oob_ff  <= b_oob_ff;
      c_word_ff <= b_word_ff;
      c_q1_ff   <= c_q1_in;
      c_q2_ff   <= c_q2_in;
   end

   // Stage C: sum once, saturate, threshold
   assign sum = {{2{c_q1_ff[47]}}, c_q1_ff} + {{2{c_q2_ff[47]}}, c_q2_ff} +
                {{18{cfg.drive_offset[31]}}, cfg.drive_offset};

   always_comb begin
      if (sum > SUM_MAX) begin
         sat = 32'sh7FFFFFFF;
      end else if (sum < SUM_MIN) begin
         sat = 32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
   end

   always_comb begin
      new_word    = c_word_ff;
      rsp_data_in = '0;
      if (c_oob_ff) begin
         rsp_data_in = '0;
      end else if (c_word_ff.refr != '0) begin
         // Refractory: count down only
         new_word.refr = c_word_ff.refr - 1'b1;
      end else if (sat >= cfg.fire_threshold) begin
         new_word.membrane   = '0;
         new_word.refr       = cfg.refractory_ticks;
         rsp_data_in.spiked  = 1'b1;
         rsp_data_in.spike_id = cfg.id_offset + {12'd0, c_idx_ff};
      end else begin
         new_word.membrane = sat;
      end
      if (!c_oob_ff) begin
         rsp_data_in.membrane_out    = new_word.membrane;
         rsp_data_in.refractory_left = new_word.refr;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No beat is in flight while the memory is being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !a_valid_ff && !b_valid_ff && !c_valid_ff)
      else $error("pipeline active during clearing pass");

   // Never two in-flight beats for the same neuron
   a_no_alias: assert property (@(posedge clock) disable iff (reset)
      !((a_valid_ff && b_valid_ff && !a_oob_ff && !b_oob_ff && a_idx_ff == b_idx_ff) ||
        (a_valid_ff && c_valid_ff && !a_oob_ff && !c_oob_ff && a_idx_ff == c_idx_ff) ||
        (b_valid_ff && c_valid_ff && !b_oob_ff && !c_oob_ff && b_idx_ff == c_idx_ff)))
      else $error("same neuron in flight twice");

   // A spike clears the membrane and loads the refractory period
   a_spike_reset: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && !c_oob_ff && c_word_ff.refr == '0 && sat >= cfg.fire_threshold
      |=> rsp_valid && rsp_data.spiked && rsp_data.membrane_out == '0 &&
          rsp_data.refractory_left == $past(cfg.refractory_ticks))
      else $error("spike did not reset neuron state");

   // Silent results carry no spike id
   a_silent_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.spiked |-> rsp_data.spike_id == '0)
      else $error("spike id without spike");

endmodule

// ----- hw/rtl/lif_neuron_membrane_update.sv -----
// A beat accepted into the queue goes through stages A, B and C and a result register.
// Throughput: one beat per cycle while no beat names a neuron of the three beats
// before it; such a beat waits in the 4-entry queue until the 3-stage update is done.
// Reset: after reset a clearing pass zeroes NEURONS state words, one per cycle,
// with busy high for NEURONS cycles; config registers reset to zero.
// The result side cannot stall: each result is shown for one cycle.
module lif_neuron_membrane_update #(
   parameter int NEURONS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  lif_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   output lif_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [lif_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [lif_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   lif_pkg::cfg_type   cfg_ff;
   lif_pkg::cfg_type   cfg_in;
   lif_pkg::qhead_type qhead;
   lif_pkg::bctl_type  bctl;

   // Register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lif_pkg::CSR_DECAY_GAIN:       cfg_in.decay_gain       = csr_wdata;
            lif_pkg::CSR_CURRENT_GAIN:     cfg_in.current_gain     = csr_wdata;
            lif_pkg::CSR_DRIVE_OFFSET:     cfg_in.drive_offset     = csr_wdata;
            lif_pkg::CSR_FIRE_THRESHOLD:   cfg_in.fire_threshold   = csr_wdata;
            lif_pkg::CSR_REFRACTORY_TICKS: cfg_in.refractory_ticks = csr_wdata[6:0];
            lif_pkg::CSR_ID_OFFSET:        cfg_in.id_offset        = csr_wdata[23:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lif_front #(
      .NEURONS (NEURONS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .bctl     (bctl),
      .qhead    (qhead)
   );

   lif_back #(
      .NEURONS (NEURONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .qhead     (qhead),
      .bctl      (bctl),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/lif_neuron_membrane_update_tb.sv -----
`timescale 1ns / 100ps

module lif_neuron_membrane_update_tb;

   localparam int NEURON_COUNT = 4096;
   // indexes past the last register; writes there must be dropped
   localparam logic [lif_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [lif_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [31:0] Q_ONE      = 32'sh0001_0000;
   localparam logic signed [31:0] Q_HALF     = 32'sh0000_8000;
   localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   lif_pkg::req_type                req_data = '0;
   logic                            rsp_valid;
   lif_pkg::rsp_type                rsp_data;
   logic                            csr_we = 1'b0;
   logic [lif_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lif_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the neuron array and its registers
   logic signed [31:0] membrane_shadow [NEURON_COUNT];
   logic        [6:0]  refractory_shadow [NEURON_COUNT];
   lif_pkg::cfg_type   neuron_cfg = '0;

   lif_pkg::rsp_type expected_updates [$];
   int      mismatch_count = 0;
   bit      gaps_on = 1'b1;

   lif_neuron_membrane_update #(
      .NEURONS(NEURON_COUNT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NEURON_COUNT; i++) begin
         membrane_shadow[i]   = '0;
         refractory_shadow[i] = '0;
      end
   end

   // Q16.16 product, exact then rounded half up
   function automatic longint round_mul(logic signed [31:0] a, logic signed [31:0] b);
      longint prod;
      prod = longint'(a) * longint'(b);
      return (prod + 64'sd32768) >>> 16;
   endfunction

   // one neuron tick against the shadow state
   function automatic lif_pkg::rsp_type predict_neuron_update(lif_pkg::req_type beat);
      lif_pkg::rsp_type   res;
      longint             sum;
      logic signed [31:0] level;
      logic signed [31:0] mem;
      logic        [6:0]  cnt;
      res = '0;
      if (beat.neuron_index >= NEURON_COUNT) return res;
      mem = membrane_shadow[beat.neuron_index];
      cnt = refractory_shadow[beat.neuron_index];
      if (cnt != 0) begin
         cnt = cnt - 7'd1;
      end else begin
         sum = round_mul(mem, neuron_cfg.decay_gain) + longint'(neuron_cfg.drive_offset)
               + round_mul(beat.syn_current, neuron_cfg.current_gain);
         if (sum > 64'sd2147483647) level = Q_MAX;
         else if (sum < -64'sd2147483648) level = Q_MIN;
         else level = sum[31:0];
         if (level >= neuron_cfg.fire_threshold) begin
            res.spiked   = 1'b1;
            res.spike_id = neuron_cfg.id_offset + {12'd0, beat.neuron_index};
            mem          = '0;
            cnt          = neuron_cfg.refractory_ticks;
         end else begin
            mem = level;
         end
      end
      membrane_shadow[beat.neuron_index]   = mem;
      refractory_shadow[beat.neuron_index] = cnt;
      res.membrane_out    = mem;
      res.refractory_left = cnt;
      return res;
   endfunction

   // result checker: every strobed beat against the oldest prediction
   always @(posedge clock) begin : check_results
      lif_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_updates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result beat with nothing pending: %p", $realtime, rsp_data);
         end else begin
            want = expected_updates.pop_front();
            if (rsp_data.spiked !== want.spiked || rsp_data.spike_id !== want.spike_id ||
                rsp_data.membrane_out !== want.membrane_out ||
                rsp_data.refractory_left !== want.refractory_left) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch spiked %0b/%0b id %h/%h membrane %h/%h refr %0d/%0d",
                           $realtime, want.spiked, rsp_data.spiked, want.spike_id,
                           rsp_data.spike_id, want.membrane_out, rsp_data.membrane_out,
                           want.refractory_left, rsp_data.refractory_left);
            end
         end
      end
   end

   // send one beat, with random idle cycles ahead of it when gaps are on
   task automatic send_beat(input logic [11:0] idx, input logic [31:0] cur);
      lif_pkg::req_type beat;
      beat.neuron_index = idx;
      beat.syn_current  = cur;
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 32) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      expected_updates.push_back(predict_neuron_update(beat));
   endtask

   // stop sending and wait until every prediction has been matched
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lif_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lif_pkg::CSR_DECAY_GAIN:       neuron_cfg.decay_gain       = value;
         lif_pkg::CSR_CURRENT_GAIN:     neuron_cfg.current_gain     = value;
         lif_pkg::CSR_DRIVE_OFFSET:     neuron_cfg.drive_offset     = value;
         lif_pkg::CSR_FIRE_THRESHOLD:   neuron_cfg.fire_threshold   = value;
         lif_pkg::CSR_REFRACTORY_TICKS: neuron_cfg.refractory_ticks = value[6:0];
         lif_pkg::CSR_ID_OFFSET:        neuron_cfg.id_offset        = value[23:0];
         default: ;
      endcase
   endtask

   // program all registers once the block is quiet
   task automatic load_config(input logic [31:0] decay, input logic [31:0] cur_gain,
                              input logic [31:0] drive, input logic [31:0] thresh,
                              input logic [6:0] ticks, input logic [23:0] id_base);
      drain_results();
      write_csr(lif_pkg::CSR_DECAY_GAIN, decay);
      write_csr(lif_pkg::CSR_CURRENT_GAIN, cur_gain);
      write_csr(lif_pkg::CSR_DRIVE_OFFSET, drive);
      write_csr(lif_pkg::CSR_FIRE_THRESHOLD, thresh);
      write_csr(lif_pkg::CSR_REFRACTORY_TICKS, {25'd0, ticks});
      write_csr(lif_pkg::CSR_ID_OFFSET, {8'd0, id_base});
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // registers at reset value: every update lands on threshold zero and fires
   task automatic test_power_up_defaults();
      send_beat(12'd0, Q_MAX);
      send_beat(12'd4095, Q_MIN);
      send_beat(12'd1, 32'd0);
   endtask

   // sums that clip at both ends of the Q16.16 range
   task automatic test_saturation();
      load_config(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 7'd0, 24'd0);
      send_beat(12'd10, Q_MAX);
      load_config(Q_MAX, Q_MAX, Q_MIN, Q_MAX, 7'd0, 24'd0);
      send_beat(12'd11, Q_MIN);
      send_beat(12'd11, Q_MIN);
      send_beat(12'd11, Q_MAX);
      load_config(Q_MAX, Q_MIN, 32'd0, Q_MAX, 7'd0, 24'd0);
      send_beat(12'd12, Q_MIN);
      send_beat(12'd13, Q_MAX);
   endtask

   // half-LSB products round up, for either sign
   task automatic test_rounding();
      load_config(Q_ONE, Q_HALF, 32'd0, Q_MAX, 7'd0, 24'd0);
      send_beat(12'd20, 32'sd1);
      send_beat(12'd20, -32'sd1);
      send_beat(12'd20, -32'sd3);
      send_beat(12'd20, 32'sd3);
   endtask

   // countdown after a spike, spike id wrapping past 24 bits, longest refractory load
   task automatic test_refractory_and_id_wrap();
      load_config(32'd0, Q_ONE, 32'd0, Q_ONE, 7'd3, 24'hFFFFF0);
      send_beat(12'd4095, Q_ONE);
      repeat (4) send_beat(12'd4095, 32'h0002_0000);
      load_config(32'd0, Q_ONE, 32'd0, Q_ONE, 7'd127, 24'hFFFFFF);
      send_beat(12'd30, Q_ONE);
      send_beat(12'd30, Q_ONE);
   endtask

   // writes to indexes with no register behind them change nothing
   task automatic test_spare_csr_index();
      drain_results();
      write_csr(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE_HI, 32'hFFFF_FFFF);
      @(negedge clock);
      csr_we <= 1'b0;
      send_beat(12'd31, Q_ONE);
   endtask

   // the sender holds off mid-stream until the block has gone quiet
   task automatic test_mid_stream_pause();
      load_config(32'h0000_C000, Q_ONE, 32'h0000_1000, 32'h0003_0000, 7'd2, 24'd100);
      for (int n = 0; n < 30; n++) begin
         if (n == 15) drain_results();
         send_beat(12'd200 + 12'($urandom_range(3)), 32'($urandom_range(32'h0002_0000)));
      end
   endtask

   // random phases: mostly integrating neurons that spike, some wild settings
   task automatic test_random_traffic();
      logic [11:0] pool_base;
      logic [31:0] cur;
      logic [11:0] idx;
      bit          wild;
      logic [6:0]  ticks;
      for (int phase = 0; phase < 10; phase++) begin
         wild = (phase % 3 == 2);
         if ($urandom_range(9) == 0) ticks = 7'd127;
         else ticks = 7'($urandom_range(5));
         if (wild)
            load_config($urandom, $urandom, $urandom, $urandom,
                        7'($urandom_range(127)), 24'($urandom));
         else
            load_config($urandom_range(32'h0001_0000, 32'h0000_8000),
                        $urandom_range(32'h0001_4000, 32'h0000_4000),
                        32'($urandom_range(32'h0000_8000)) - 32'h0000_4000,
                        $urandom_range(32'h0006_0000, 32'h0001_0000),
                        ticks, 24'($urandom));
         pool_base = (phase == 1) ? 12'd4090 : 12'($urandom_range(4090));
         gaps_on   = (phase != 4);
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(99) < 85) begin
               idx = pool_base + 12'($urandom_range(5));
               cur = 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
            end else begin
               idx = 12'($urandom_range(4095));
               cur = $urandom;
            end
            send_beat(idx, cur);
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset
      @(posedge clock);
      while (busy) @(posedge clock);
      test_power_up_defaults();
      test_saturation();
      test_rounding();
      test_refractory_and_id_wrap();
      test_spare_csr_index();
      test_mid_stream_pause();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- lif_neuron_membrane_update.f -----
hw/rtl/lif_pkg.sv
hw/rtl/lif_front.sv
hw/rtl/lif_back.sv
hw/rtl/lif_neuron_membrane_update.sv
tb/lif_neuron_membrane_update_tb.sv
